// ----- rtl/core/pcl_pkg.sv -----
// Package for positional_char_list: request and result beat types, request
// and status codes, and the controller/datapath command and status structs.
// No dependencies.
package pcl_pkg;

  localparam int unsigned TYPE_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;

  localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  list_length;
    logic              has_value;
    logic [BYTE_W-1:0] elem_value;
    logic              last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // capture the input beat
    logic exec;        // apply a single-result request and load its result
    logic dump_start;  // clear the dump counter
    logic dump_step;   // emit head element and rotate the list
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_dump;    // held request is a dump
    logic nonempty;    // list holds at least one element
    logic out_free;    // output register can take a beat this cycle
    logic dump_last;   // current dump step emits the final element
  } sts_t;

endpackage

// ----- rtl/core/positional_char_list.sv -----
// Top level of positional_char_list: ordered byte list with append, insert,
// delete, clear and dump requests. Depends on pcl_pkg, pcl_ctrl, pcl_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one request
//   beat: req_type, 1-based position, byte_value. Output channel
//   (out_valid_o / out_ready_i / out_data_o) carries result beats: status,
//   list_length, has_value, elem_value and last.
//   Every request except a dump of a non-empty list yields one result beat
//   with last set. A dump of N elements yields N beats, in list order, last
//   set on the final one.
//   A request is taken in S_IDLE and executed in S_EXEC once the output
//   register is free; its result is registered into the output register.
//   A dump of N elements clears the dump counter in S_EXEC, then emits the
//   head slot and rotates the store one element per cycle while the output
//   register is free. The controller handles one request at a time; that
//   sequencer sets the rate. The next request is taken while a result still
//   sits in the output register.
//   Reset empties the list (count to zero); slot contents are not cleared
//   and are only read after being written.
//   When the receiver stalls, the output register holds its beat and the
//   controller waits before loading the next one; input is held off until
//   the current request has finished.
module positional_char_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pcl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pcl_pkg::rsp_t out_data_o
);
  import pcl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence accept, execute and dump steps
  pcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the list, count and output beat
  pcl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/pcl_ctrl.sv -----
// Controller for positional_char_list: sequences accept, execute and dump.
// Depends on pcl_pkg.
module pcl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pcl_pkg::sts_t sts_i,
  output pcl_pkg::cmd_t cmd_o
);
  import pcl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.req_dump && sts_i.nonempty) begin
          cmd_o.dump_start = 1'b1;
          state_d          = S_DUMP;
        end else if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.dump_step = 1'b1;
          if (sts_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_req, cmd_o.exec, cmd_o.dump_start, cmd_o.dump_step}))
    else $error("more than one datapath command at once");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> (state_q == S_EXEC))
    else $error("accepted beat did not move to execute");

  a_dump_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.dump_step && sts_i.dump_last) |=> in_ready_o)
    else $error("dump end did not return to idle");

endmodule

// ----- rtl/core/pcl_datapath.sv -----
// Datapath for positional_char_list: request register, shifting element
// store, element count, dump counter and output register. Depends on pcl_pkg.
module pcl_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcl_pkg::req_t in_data_i,
  input  pcl_pkg::cmd_t cmd_i,
  output pcl_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pcl_pkg::rsp_t out_data_o
);
  import pcl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  req_t              req_q;
  logic [BYTE_W-1:0] slot_q [CAPACITY];
  logic [BYTE_W-1:0] slot_d [CAPACITY];
  logic [BYTE_W-1:0] slot_up [CAPACITY];
  logic [BYTE_W-1:0] slot_dn [CAPACITY];
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     k_q;
  logic              out_valid_q;
  rsp_t              out_q, out_d;

  logic [PW-1:0]     cnt_ext, pos_ext, ins_idx, del_idx;
  logic              full, pos_zero, do_ins, do_del, do_clr;
  logic [STAT_W-1:0] status;
  logic [PW-1:0]     new_len;

  assign cnt_ext  = PW'(count_q);
  assign pos_ext  = PW'(req_q.position);
  assign full     = (count_q == CW'(CAPACITY));
  assign pos_zero = (req_q.position == '0);
  assign del_idx  = pos_ext - PW'(1);

  // decode the held request
  always_comb begin
    status  = ST_DONE;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    do_clr  = 1'b0;
    ins_idx = cnt_ext;
    case (req_q.req_type)
      REQ_APPEND: begin
        if (full) status = ST_FULL;
        else      do_ins = 1'b1;
      end
      REQ_INSERT: begin
        ins_idx = pos_ext - PW'(1);
        if (pos_zero || pos_ext > cnt_ext + PW'(1)) status = ST_RANGE;
        else if (full)                                status = ST_FULL;
        else                                          do_ins = 1'b1;
      end
      REQ_DELETE: begin
        if (pos_zero || pos_ext > cnt_ext) status = ST_RANGE;
        else                               do_del = 1'b1;
      end
      REQ_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.exec) begin
      if (do_clr)      count_d = '0;
      else if (do_ins) count_d = count_q + CW'(1);
      else if (do_del) count_d = count_q - CW'(1);
    end
  end

  // per-slot lane: insert shifts up, delete shifts down, dump rotates
  for (genvar g = 0; g < CAPACITY; g++) begin : g_lane
    localparam int unsigned UP = (g == CAPACITY - 1) ? g : g + 1;
    localparam int unsigned DN = (g == 0) ? 0 : g - 1;
    logic [PW-1:0] idx;
    assign idx        = PW'(g);
    assign slot_up[g] = slot_q[UP];
    assign slot_dn[g] = slot_q[DN];

    always_comb begin
      slot_d[g] = slot_q[g];
      if (cmd_i.exec && do_ins) begin
        if (idx == ins_idx)     slot_d[g] = req_q.byte_value;
        else if (idx > ins_idx) slot_d[g] = slot_dn[g];
      end else if (cmd_i.exec && do_del) begin
        if (idx >= del_idx) slot_d[g] = slot_up[g];
      end else if (cmd_i.dump_step) begin
        if (idx == cnt_ext - PW'(1)) slot_d[g] = slot_q[0];
        else                         slot_d[g] = slot_up[g];
      end
    end

    always_ff @(posedge clk_i) begin
      slot_q[g] <= slot_d[g];
    end
  end

  assign new_len = PW'(count_d);

  always_comb begin
    out_d = out_q;
    if (cmd_i.exec) begin
      out_d.status      = status;
      out_d.list_length = new_len[LEN_W-1:0];
      out_d.has_value   = 1'b0;
      out_d.elem_value  = '0;
      out_d.last        = 1'b1;
    end else if (cmd_i.dump_step) begin
      out_d.status      = ST_DONE;
      out_d.list_length = cnt_ext[LEN_W-1:0];
      out_d.has_value   = 1'b1;
      out_d.elem_value  = slot_q[0];
      out_d.last        = sts_o.dump_last;
    end
  end

  assign sts_o.req_dump  = (req_q.req_type == REQ_DUMP);
  assign sts_o.nonempty  = (count_q != '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.dump_last = (PW'(k_q) + PW'(1) == cnt_ext);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_data_i;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.dump_start)     k_q <= '0;
      else if (cmd_i.dump_step) k_q <= k_q + CW'(1);
      if (cmd_i.exec || cmd_i.dump_step) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec || cmd_i.dump_step) |-> sts_o.out_free)
    else $error("output beat overwritten");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dump_step |-> (count_q != '0))
    else $error("dump step on empty list");

  a_value_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.has_value) |-> (out_q.status == ST_DONE))
    else $error("dumped element with error status");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for positional_char_list: a directed table, then random traffic in
// episodes, checked beat by beat against a local list predictor or a typed row's own result.
// Depends on pcl_pkg and the positional_char_list RTL.
module tb;
  import pcl_pkg::*;

  localparam int unsigned LIST_CAP    = 16;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_CYC   = 12;
  localparam int unsigned RAND_ITEMS  = 260;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned PRINT_LIMIT = 40;

  // Request kinds the block ignores (one plain result each).
  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

  // Shapes of random episodes.
  typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_BOTH, MIX_NOISE} mix_e;

  // One row of the directed table. A typed row carries its own result,
  // which always has has_value 0, elem_value 0 and last 1.
  typedef struct packed {
    req_t              req;
    int unsigned       reps;
    logic              typed;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  req_t  in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  rsp_t  out_data;

  // Typed result that travels with the request being driven.
  logic  typed_pending = 1'b0;
  rsp_t  typed_rsp = '0;

  // Predictor state: the list contents and its length.
  logic [BYTE_W-1:0] list_bytes [LIST_CAP];
  int unsigned       list_len = 0;

  rsp_t        beats_new [$];
  rsp_t        beats_due [$];
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rdy_mode = 0;
  int unsigned rdy_phase_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  positional_char_list #(
    .CAPACITY (LIST_CAP)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic stim_row_t row(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                                    logic [BYTE_W-1:0] val, int unsigned reps,
                                    logic typed, logic [STAT_W-1:0] st,
                                    logic [LEN_W-1:0] len);
    stim_row_t r;
    r.req    = '{req_type: kind, position: pos, byte_value: val};
    r.reps   = reps;
    r.typed  = typed;
    r.status = st;
    r.length = len;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Build one result beat from the predictor's current length.
  function automatic rsp_t make_beat(logic [STAT_W-1:0] st, logic has, logic [BYTE_W-1:0] val,
                                     logic fin);
    rsp_t b;
    b.status      = st;
    b.list_length = LEN_W'(list_len);
    b.has_value   = has;
    b.elem_value  = val;
    b.last        = fin;
    return b;
  endfunction

  // Apply one request to the list and leave its result beats in beats_new.
  task automatic list_apply(input req_t r);
    int unsigned       p;
    int unsigned       j;
    logic [STAT_W-1:0] st;
    p  = r.position;
    st = ST_DONE;
    beats_new.delete();
    case (r.req_type)
      REQ_APPEND: begin
        if (list_len >= LIST_CAP) begin
          st = ST_FULL;
        end else begin
          list_bytes[list_len] = r.byte_value;
          list_len++;
        end
      end
      REQ_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          st = ST_RANGE;
        end else if (list_len >= LIST_CAP) begin
          st = ST_FULL;
        end else begin
          // shift the tail up one slot, then drop the byte into the gap
          for (j = list_len; j >= p; j--) list_bytes[j] = list_bytes[j-1];
          list_bytes[p-1] = r.byte_value;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (p < 1 || p > list_len) begin
          st = ST_RANGE;
        end else begin
          for (j = p; j < list_len; j++) list_bytes[j-1] = list_bytes[j];
          list_len--;
        end
      end
      REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    if (r.req_type == REQ_DUMP && list_len > 0) begin
      for (j = 0; j < list_len; j++)
        beats_new.push_back(make_beat(ST_DONE, 1'b1, list_bytes[j], j + 1 == list_len));
    end else begin
      beats_new.push_back(make_beat(st, 1'b0, '0, 1'b1));
    end
  endtask

  // Draw one random request; the episode shape decides the mix, and valid
  // positions are picked from the current predicted length.
  function automatic req_t pick_request(mix_e mix);
    req_t        r;
    int unsigned dice;
    r.req_type   = REQ_APPEND;
    r.position   = POS_W'($urandom_range(0, 31));
    r.byte_value = BYTE_W'($urandom_range(0, 255));
    dice = $urandom_range(0, 7);
    if (dice == 0) r.byte_value = '0;
    if (dice == 1) r.byte_value = '1;
    dice = $urandom_range(0, 11);
    case (mix)
      MIX_GROW: begin
        if (dice < 7) begin
          r.req_type = REQ_APPEND;
        end else if (dice < 11) begin
          r.req_type = REQ_INSERT;
          r.position = POS_W'($urandom_range(1, list_len + 1));
        end else begin
          r.req_type = REQ_DUMP;
        end
      end
      MIX_SHRINK: begin
        if (dice < 8) begin
          r.req_type = REQ_DELETE;
          if (list_len > 0) r.position = POS_W'($urandom_range(1, list_len));
        end else if (dice < 10) begin
          r.req_type = REQ_DELETE;
          r.position = ($urandom_range(0, 3) == 0) ? '0
                       : POS_W'($urandom_range(list_len + 1, 31));
        end else if (dice < 11) begin
          r.req_type = REQ_DUMP;
        end else begin
          r.req_type = REQ_INSERT;
          r.position = POS_W'($urandom_range(1, list_len + 1));
        end
      end
      MIX_BOTH: begin
        if (dice < 3) begin
          r.req_type = REQ_APPEND;
        end else if (dice < 6) begin
          r.req_type = REQ_INSERT;
          if ($urandom_range(0, 4) != 0) r.position = POS_W'($urandom_range(1, list_len + 1));
        end else if (dice < 9) begin
          r.req_type = REQ_DELETE;
          if ($urandom_range(0, 4) != 0 && list_len > 0)
            r.position = POS_W'($urandom_range(1, list_len));
        end else if (dice < 11) begin
          r.req_type = REQ_DUMP;
        end else begin
          r.req_type = REQ_CLEAR;
        end
      end
      default: begin
        // raw noise: any kind, unused ones included, any position
        r.req_type = TYPE_W'($urandom_range(0, 7));
      end
    endcase
    return r;
  endfunction

  // Drive one request beat and hold it until taken. Between bursts drop
  // valid for a random gap; inside a burst the next beat follows at once.
  task automatic send_req(input req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 6);
    end
  endtask

  // Receiver: switch between stall patterns, each held for a random-length phase.
  always @(negedge clk) begin
    if (rdy_phase_left == 0) begin
      rdy_mode       <= $urandom_range(0, 3);
      rdy_phase_left <= $urandom_range(10, 80);
    end else begin
      rdy_phase_left <= rdy_phase_left - 1;
    end
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 2) == 0);
      default: out_ready <= (rdy_phase_left[2:0] == 3'd0);  // long stalls
    endcase
  end

  // Monitor: on every taken request advance the predictor and queue its
  // beats; on every taken result compare against the oldest queued beat.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        list_apply(in_data);
        if (typed_pending) begin
          beats_due.push_back(typed_rsp);
        end else begin
          foreach (beats_new[k]) beats_due.push_back(beats_new[k]);
        end
      end
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %p", out_data));
        end else begin
          want = beats_due.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d", out_data.status, want.status));
          if (out_data.list_length !== want.list_length)
            report_mismatch($sformatf("list_length got %0d exp %0d",
                                      out_data.list_length, want.list_length));
          if (out_data.has_value !== want.has_value)
            report_mismatch($sformatf("has_value got %0d exp %0d",
                                      out_data.has_value, want.has_value));
          if (out_data.elem_value !== want.elem_value)
            report_mismatch($sformatf("elem_value got %02h exp %02h",
                                      out_data.elem_value, want.elem_value));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last got %0d exp %0d", out_data.last, want.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t   dir_table [$];
    req_t        r;
    mix_e        mix;
    int unsigned rand_count;
    int unsigned dice;

    // Directed table. Typed rows: empty list after reset, range and full
    // rejects, unused kinds, the first append, clear. Everything else goes through the predictor.
    dir_table = '{
      row(REQ_DUMP,      5'd0,  8'h00, 1,  1'b1, ST_DONE,  5'd0),   // dump of empty list
      row(REQ_DELETE,    5'd1,  8'h00, 1,  1'b1, ST_RANGE, 5'd0),   // delete from empty
      row(REQ_INSERT,    5'd0,  8'h11, 1,  1'b1, ST_RANGE, 5'd0),   // position zero
      row(REQ_INSERT,    5'd31, 8'hFF, 1,  1'b1, ST_RANGE, 5'd0),   // position far past end
      row(REQ_UNUSED_HI, 5'd31, 8'hFF, 1,  1'b1, ST_DONE,  5'd0),   // unused kind, all ones
      row(REQ_UNUSED_LO, 5'd7,  8'h3C, 1,  1'b1, ST_DONE,  5'd0),
      row(REQ_APPEND,    5'd31, 8'h00, 1,  1'b1, ST_DONE,  5'd1),   // position ignored
      row(REQ_INSERT,    5'd1,  8'hFF, 1,  1'b0, ST_DONE,  5'd0),   // at head
      row(REQ_INSERT,    5'd3,  8'h5A, 1,  1'b0, ST_DONE,  5'd0),   // at length+1
      row(REQ_INSERT,    5'd2,  8'hA5, 1,  1'b0, ST_DONE,  5'd0),   // in the middle
      row(REQ_DELETE,    5'd0,  8'h77, 1,  1'b1, ST_RANGE, 5'd4),
      row(REQ_DELETE,    5'd5,  8'h00, 1,  1'b1, ST_RANGE, 5'd4),   // one past the end
      row(REQ_DUMP,      5'd31, 8'hFF, 1,  1'b0, ST_DONE,  5'd0),
      row(REQ_APPEND,    5'd0,  8'hC0, 12, 1'b0, ST_DONE,  5'd0),   // fill to capacity
      row(REQ_APPEND,    5'd0,  8'h99, 1,  1'b1, ST_FULL,  5'd16),  // append to full list
      row(REQ_INSERT,    5'd1,  8'h99, 1,  1'b1, ST_FULL,  5'd16),  // full, good position
      row(REQ_INSERT,    5'd17, 8'h99, 1,  1'b1, ST_FULL,  5'd16),  // full, at length+1
      row(REQ_INSERT,    5'd18, 8'h99, 1,  1'b1, ST_RANGE, 5'd16),  // full, bad position
      row(REQ_DUMP,      5'd0,  8'h00, 1,  1'b0, ST_DONE,  5'd0),   // longest dump
      row(REQ_DELETE,    5'd16, 8'hFF, 1,  1'b0, ST_DONE,  5'd0),   // last element
      row(REQ_DELETE,    5'd1,  8'h00, 1,  1'b0, ST_DONE,  5'd0),   // first element
      row(REQ_DUMP,      5'd0,  8'h00, 1,  1'b0, ST_DONE,  5'd0),
      row(REQ_CLEAR,     5'd31, 8'hFF, 1,  1'b1, ST_DONE,  5'd0),   // clear the whole list
      row(REQ_DUMP,      5'd0,  8'h00, 1,  1'b1, ST_DONE,  5'd0)    // empty again
    };

    // Hold reset, then release it away from the rising edge.
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    burst_left = $urandom_range(0, 6);

    foreach (dir_table[i]) begin
      for (int unsigned k = 0; k < dir_table[i].reps; k++) begin
        r = dir_table[i].req;
        r.byte_value = r.byte_value + BYTE_W'(k);  // keep repeated bytes distinct
        typed_pending <= dir_table[i].typed;
        typed_rsp     <= '{status: dir_table[i].status, list_length: dir_table[i].length,
                           has_value: 1'b0, elem_value: '0, last: 1'b1};
        send_req(r);
      end
    end

    // Random part: episodes of one shape each, mostly well-formed traffic
    // that grows and shrinks the list, with some raw noise mixed in.
    typed_pending <= 1'b0;
    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      dice = $urandom_range(0, 9);
      mix  = (dice < 4) ? MIX_GROW : (dice < 7) ? MIX_SHRINK : (dice < 9) ? MIX_BOTH : MIX_NOISE;
      repeat ($urandom_range(4, 24)) begin
        r = pick_request(mix);
        send_req(r);
        if (r.req_type <= REQ_DUMP) rand_count++;
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding beats, then watch a while for strays.
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pcl_pkg.sv
rtl/core/pcl_ctrl.sv
rtl/core/pcl_datapath.sv
rtl/core/positional_char_list.sv
sim/tb.sv
